// ----- src/trpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package trpa_pkg;

    // Region geometry
    localparam int KPAGES     = 1024;
    localparam int UMAX_PAGES = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_BURST  = 64;

    // Field widths
    localparam int ADDR_W    = 56;
    localparam int PN_W      = ADDR_W - PAGE_SHIFT;
    localparam int KIDX_W    = $clog2(KPAGES);
    localparam int UIDX_W    = $clog2(UMAX_PAGES);
    localparam int IDX_W     = (KIDX_W > UIDX_W) ? KIDX_W : UIDX_W;
    localparam int KCNT_W    = $clog2(KPAGES + 1);
    localparam int CNT_W     = 16;
    localparam int WANT_W    = 7;
    localparam int LEFT_W    = $clog2(MAX_BURST + 1);
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 3;
    localparam int SUM_W     = PN_W + 2;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = ((ADDR_W + WANT_W + 7) / 8) * 8;
    localparam int IN_USER_W  = MODE_W + 1;
    localparam int OUT_DATA_W = ((ADDR_W + CNT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ADDR_W;

    // Reset values of the registers
    localparam logic [ADDR_W-1:0] BASE_RST   = ADDR_W'(64'h8000_0000);
    localparam logic [CNT_W-1:0]  UPAGES_RST = CNT_W'(31744);

    typedef enum logic [MODE_W-1:0] {
        MODE_FREE  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_MISALIGNED  = 3'd1,
        STAT_OUT_OF_RGN  = 3'd2,
        STAT_DOUBLE_FREE = 3'd3,
        STAT_NONE_AVAIL  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALLOC_BASE = 1'b0,
        CFG_USER_PAGES = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FSUB,
        S_FCHK,
        S_FMAP,
        S_POPRD,
        S_POPEM,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ----- src/trpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- src/two_region_page_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-region page allocator: kernel region and user region, each a LIFO stack of free
// page indices with a free flag per page and a free count.
// Input stream (s side): tuser carries mode and region select, tdata the page address
// and the wanted page count. Output stream (m side): tuser carries the status, tdata the
// granted address and the free count after the item, tlast marks the last result.
// Configuration channel: index 0 writes the kernel base address (rounded up to a page),
// index 1 the user page count (clamped to the user region maximum). Every write frees
// all pages again and needs no clearing pass, since a fill mark per region tells which
// stack entries and free flags were never written since.
// Steps per item, from accept to result in the output register: a query goes straight
// to its result; a free does address subtract, range check, free flag read and push;
// an allocation does, per granted page, a stack read, then a free flag write and an
// address add in the shared adder. The next item is accepted as soon as the last
// result of the current one has been registered.
// Reset acts as a configuration write with the default values.
// A stalled receiver holds the output register; the sequencer then waits in place and
// the block keeps s_tready low until the item's last result has been registered.
module two_region_page_allocator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [55:0] page_addr, [62:56] want_count, [63] zero
    input  wire logic [trpa_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] mode, [2] in_kernel
    input  wire logic [trpa_pkg::IN_USER_W-1:0]      i_s_tuser,
    // results
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [55:0] granted_addr, [71:56] free_pages
    output logic      [trpa_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // [2:0] status
    output logic      [trpa_pkg::STAT_W-1:0]         o_m_tuser,
    output logic                                     o_m_tlast,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [trpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [trpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import trpa_pkg::*;

    // ---------------------------------------------------------------- registers
    t_state                r_state, n_state;
    logic                  r_kern, n_kern;
    logic [PN_W-1:0]       r_addr_pn, n_addr_pn;
    logic                  r_misal, n_misal;
    t_status               r_status, n_status;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic [CNT_W-1:0]      r_final, n_final;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_from_init, n_from_init;
    logic [IDX_W-1:0]      r_init_idx, n_init_idx;
    logic [SUM_W-1:0]      r_diff, n_diff;

    // region setup and per-region counters
    logic [PN_W-1:0]       r_kpn, n_kpn;
    logic [PN_W:0]         r_upn;
    logic [CNT_W-1:0]      r_usize, n_usize;
    logic [KCNT_W-1:0]     r_kcnt, n_kcnt;
    logic [KCNT_W-1:0]     r_kw, n_kw;
    logic [CNT_W-1:0]      r_ucnt, n_ucnt;
    logic [CNT_W-1:0]      r_uw, n_uw;

    // output register
    logic                  r_m_valid, n_m_valid;
    t_status               r_m_status, n_m_status;
    logic [ADDR_W-1:0]     r_m_addr, n_m_addr;
    logic [CNT_W-1:0]      r_m_free, n_m_free;
    logic                  r_m_last, n_m_last;

    // ---------------------------------------------------------------- memories
    logic                  ks_we, ks_re, us_we, us_re;
    logic [KIDX_W-1:0]     ks_waddr, ks_raddr, ks_wdata, ks_rdata;
    logic [UIDX_W-1:0]     us_waddr, us_raddr, us_wdata, us_rdata;
    logic                  km_we, km_re, km_wdata, km_rdata;
    logic                  um_we, um_re, um_wdata, um_rdata;
    logic [KIDX_W-1:0]     km_waddr, km_raddr;
    logic [UIDX_W-1:0]     um_waddr, um_raddr;

    trpa_ram #(.WIDTH(KIDX_W), .DEPTH(KPAGES)) u_kstack (
        .i_clk  (i_clk),
        .i_we   (ks_we),
        .i_waddr(ks_waddr),
        .i_wdata(ks_wdata),
        .i_re   (ks_re),
        .i_raddr(ks_raddr),
        .o_rdata(ks_rdata)
    );

    trpa_ram #(.WIDTH(UIDX_W), .DEPTH(UMAX_PAGES)) u_ustack (
        .i_clk  (i_clk),
        .i_we   (us_we),
        .i_waddr(us_waddr),
        .i_wdata(us_wdata),
        .i_re   (us_re),
        .i_raddr(us_raddr),
        .o_rdata(us_rdata)
    );

    trpa_ram #(.WIDTH(1), .DEPTH(KPAGES)) u_kmap (
        .i_clk  (i_clk),
        .i_we   (km_we),
        .i_waddr(km_waddr),
        .i_wdata(km_wdata),
        .i_re   (km_re),
        .i_raddr(km_raddr),
        .o_rdata(km_rdata)
    );

    trpa_ram #(.WIDTH(1), .DEPTH(UMAX_PAGES)) u_umap (
        .i_clk  (i_clk),
        .i_we   (um_we),
        .i_waddr(um_waddr),
        .i_wdata(um_wdata),
        .i_re   (um_re),
        .i_raddr(um_raddr),
        .o_rdata(um_rdata)
    );

    // ---------------------------------------------------------------- input fields
    t_mode                 in_mode;
    logic                  in_kern;
    logic [ADDR_W-1:0]     in_addr;
    logic [WANT_W-1:0]     in_want;
    logic [LEFT_W-1:0]     in_wantc;
    logic [CNT_W-1:0]      in_cnt;
    logic [LEFT_W-1:0]     in_n;

    assign in_mode = t_mode'(i_s_tuser[MODE_W-1:0]);
    assign in_kern = i_s_tuser[MODE_W];
    assign in_addr = i_s_tdata[ADDR_W-1:0];
    assign in_want = i_s_tdata[ADDR_W+WANT_W-1:ADDR_W];

    // Clamp the burst, then limit it to what the region holds
    assign in_wantc = (in_want > WANT_W'(MAX_BURST)) ? LEFT_W'(MAX_BURST)
                                                    : LEFT_W'(in_want);
    assign in_cnt   = in_kern ? CNT_W'(r_kcnt) : r_ucnt;
    assign in_n     = (CNT_W'(in_wantc) < in_cnt) ? in_wantc : LEFT_W'(in_cnt);

    // ---------------------------------------------------------------- region select
    logic [CNT_W-1:0]      sel_cnt, sel_w, sel_size;
    logic [PN_W:0]         sel_begin;

    assign sel_cnt   = r_kern ? CNT_W'(r_kcnt) : r_ucnt;
    assign sel_w     = r_kern ? CNT_W'(r_kw) : r_uw;
    assign sel_size  = r_kern ? CNT_W'(KPAGES) : r_usize;
    assign sel_begin = r_kern ? {1'b0, r_kpn} : r_upn;

    // ---------------------------------------------------------------- shared adder
    logic [SUM_W-1:0]      au_a, au_b, au_sum;
    logic                  au_sub;

    assign au_sum = au_sub ? (au_a - au_b) : (au_a + au_b);

    // ---------------------------------------------------------------- misc decode
    logic                  s_accept, cfg_accept, out_free;
    logic [PN_W:0]         off_pn;
    logic                  out_of_rgn;
    logic                  map_free;
    logic [CNT_W-1:0]      pos;
    logic [IDX_W-1:0]      pop_idx;
    logic [CNT_W-1:0]      new_cnt, new_w;
    logic                  cnt_we, w_we;
    logic [CNT_W-1:0]      cfg_pages;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_m_valid || i_m_tready;

    // page offset from the region start; a borrow means below the region
    assign off_pn     = r_diff[PN_W:0];
    assign out_of_rgn = r_diff[SUM_W-1] || (|off_pn[PN_W:CNT_W])
                        || (off_pn[CNT_W-1:0] >= sel_size);

    // Pages above the fill mark were never popped since setup and are still free
    assign map_free = (CNT_W'(r_idx) >= (sel_size - sel_w))
                      || (r_kern ? km_rdata : um_rdata);

    assign pos     = sel_cnt - CNT_W'(1);
    assign pop_idx = r_from_init ? r_init_idx
                                 : (r_kern ? IDX_W'(ks_rdata) : IDX_W'(us_rdata));

    assign cfg_pages = (i_cfg_data[CNT_W-1:0] > CNT_W'(UMAX_PAGES)) ? CNT_W'(UMAX_PAGES)
                                                                   : i_cfg_data[CNT_W-1:0];

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        n_kern      = r_kern;
        n_addr_pn   = r_addr_pn;
        n_misal     = r_misal;
        n_status    = r_status;
        n_left      = r_left;
        n_final     = r_final;
        n_idx       = r_idx;
        n_from_init = r_from_init;
        n_init_idx  = r_init_idx;
        n_diff      = r_diff;
        n_kpn       = r_kpn;
        n_usize     = r_usize;
        n_kcnt      = r_kcnt;
        n_kw        = r_kw;
        n_ucnt      = r_ucnt;
        n_uw        = r_uw;
        n_m_valid   = r_m_valid && !i_m_tready;
        n_m_status  = r_m_status;
        n_m_addr    = r_m_addr;
        n_m_free    = r_m_free;
        n_m_last    = r_m_last;

        au_a    = '0;
        au_b    = '0;
        au_sub  = 1'b0;
        new_cnt = sel_cnt;
        new_w   = sel_w;
        cnt_we  = 1'b0;
        w_we    = 1'b0;

        ks_we = 1'b0;  ks_waddr = sel_cnt[KIDX_W-1:0];  ks_wdata = r_idx[KIDX_W-1:0];
        us_we = 1'b0;  us_waddr = sel_cnt[UIDX_W-1:0];  us_wdata = r_idx[UIDX_W-1:0];
        ks_re = 1'b0;  ks_raddr = pos[KIDX_W-1:0];
        us_re = 1'b0;  us_raddr = pos[UIDX_W-1:0];
        km_we = 1'b0;  km_waddr = r_idx[KIDX_W-1:0];    km_wdata = 1'b1;
        um_we = 1'b0;  um_waddr = r_idx[UIDX_W-1:0];    um_wdata = 1'b1;
        km_re = 1'b0;  km_raddr = off_pn[KIDX_W-1:0];
        um_re = 1'b0;  um_raddr = off_pn[UIDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_kern    = in_kern;
                    n_addr_pn = in_addr[ADDR_W-1:PAGE_SHIFT];
                    n_misal   = |in_addr[PAGE_SHIFT-1:0];
                    n_status  = STAT_OK;
                    unique case (in_mode) inside
                        MODE_FREE: begin
                            n_state = S_FSUB;
                        end
                        MODE_ALLOC: begin
                            if (in_wantc == '0) begin
                                n_state = S_EMIT;
                            end else if (in_cnt == '0) begin
                                n_status = STAT_NONE_AVAIL;
                                n_state  = S_EMIT;
                            end else begin
                                n_left  = in_n;
                                n_final = in_cnt - CNT_W'(in_n);
                                n_state = S_POPRD;
                            end
                        end
                        MODE_QUERY, MODE_SPARE: begin
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_FSUB: begin
                // page number of the address minus region start, borrow kept on top
                au_a    = SUM_W'(r_addr_pn);
                au_b    = SUM_W'(sel_begin);
                au_sub  = 1'b1;
                n_diff  = au_sum;
                n_state = S_FCHK;
            end

            S_FCHK: begin
                if (r_misal) begin
                    n_status = STAT_MISALIGNED;
                    n_state  = S_EMIT;
                end else if (out_of_rgn) begin
                    n_status = STAT_OUT_OF_RGN;
                    n_state  = S_EMIT;
                end else begin
                    n_idx   = off_pn[IDX_W-1:0];
                    km_re   = r_kern;
                    um_re   = !r_kern;
                    n_state = S_FMAP;
                end
            end

            S_FMAP: begin
                if (map_free) begin
                    n_status = STAT_DOUBLE_FREE;
                end else if (sel_cnt < sel_size) begin
                    // push: mark free and store on top of the stack
                    km_we   = r_kern;
                    um_we   = !r_kern;
                    ks_we   = r_kern;
                    us_we   = !r_kern;
                    new_cnt = sel_cnt + CNT_W'(1);
                    cnt_we  = 1'b1;
                end
                n_state = S_EMIT;
            end

            S_POPRD: begin
                // read the top entry unless it lies below the fill mark
                n_from_init = (pos < sel_w);
                n_init_idx  = IDX_W'(sel_size - CNT_W'(1) - pos);
                ks_re       = r_kern && !(pos < sel_w);
                us_re       = !r_kern && !(pos < sel_w);
                new_cnt     = pos;
                cnt_we      = 1'b1;
                if (pos < sel_w) begin
                    new_w = pos;
                    w_we  = 1'b1;
                end
                n_state = S_POPEM;
            end

            S_POPEM: begin
                au_a = SUM_W'(sel_begin);
                au_b = SUM_W'(pop_idx);
                if (out_free) begin
                    km_waddr   = pop_idx[KIDX_W-1:0];
                    um_waddr   = pop_idx[UIDX_W-1:0];
                    km_wdata   = 1'b0;
                    um_wdata   = 1'b0;
                    km_we      = r_kern;
                    um_we      = !r_kern;
                    n_m_valid  = 1'b1;
                    n_m_status = STAT_OK;
                    n_m_addr   = {au_sum[PN_W-1:0], {PAGE_SHIFT{1'b0}}};
                    n_m_free   = r_final;
                    n_m_last   = (r_left == LEFT_W'(1));
                    n_left     = r_left - LEFT_W'(1);
                    n_state    = (r_left == LEFT_W'(1)) ? S_IDLE : S_POPRD;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_addr   = '0;
                    n_m_free   = sel_cnt;
                    n_m_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cnt_we) begin
            if (r_kern) begin
                n_kcnt = KCNT_W'(new_cnt);
            end else begin
                n_ucnt = new_cnt;
            end
        end
        if (w_we) begin
            if (r_kern) begin
                n_kw = KCNT_W'(new_w);
            end else begin
                n_uw = new_w;
            end
        end

        // Configuration write: take the register and free every page again
        if (cfg_accept) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALLOC_BASE: begin
                    n_kpn = i_cfg_data[ADDR_W-1:PAGE_SHIFT]
                            + PN_W'(|i_cfg_data[PAGE_SHIFT-1:0]);
                    n_ucnt = r_usize;
                    n_uw   = r_usize;
                end
                CFG_USER_PAGES: begin
                    n_usize = cfg_pages;
                    n_ucnt  = cfg_pages;
                    n_uw    = cfg_pages;
                end
                default: begin
                    n_ucnt = r_usize;
                    n_uw   = r_usize;
                end
            endcase
            n_kcnt = KCNT_W'(KPAGES);
            n_kw   = KCNT_W'(KPAGES);
        end
    end

    // ---------------------------------------------------------------- clocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_m_valid <= 1'b0;
            r_kpn     <= BASE_RST[ADDR_W-1:PAGE_SHIFT];
            r_upn     <= {1'b0, BASE_RST[ADDR_W-1:PAGE_SHIFT]} + (PN_W+1)'(KPAGES);
            r_usize   <= UPAGES_RST;
            r_kcnt    <= KCNT_W'(KPAGES);
            r_kw      <= KCNT_W'(KPAGES);
            r_ucnt    <= UPAGES_RST;
            r_uw      <= UPAGES_RST;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_m_valid <= n_m_valid;
            r_kpn     <= n_kpn;
            // user region starts right after the kernel pages; registered from r_kpn
            r_upn     <= {1'b0, r_kpn} + (PN_W+1)'(KPAGES);
            r_usize   <= n_usize;
            r_kcnt    <= n_kcnt;
            r_kw      <= n_kw;
            r_ucnt    <= n_ucnt;
            r_uw      <= n_uw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kern      <= n_kern;
        r_addr_pn   <= n_addr_pn;
        r_misal     <= n_misal;
        r_status    <= n_status;
        r_final     <= n_final;
        r_idx       <= n_idx;
        r_from_init <= n_from_init;
        r_init_idx  <= n_init_idx;
        r_diff      <= n_diff;
        r_m_status  <= n_m_status;
        r_m_addr    <= n_m_addr;
        r_m_free    <= n_m_free;
        r_m_last    <= n_m_last;
    end

    // ---------------------------------------------------------------- outputs
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_m_free, r_m_addr});
    assign o_m_tuser  = r_m_status;
    assign o_m_tlast  = r_m_last;

    // ---------------------------------------------------------------- assertions
    a_kcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kcnt <= KCNT_W'(KPAGES))
        else $error("kernel free count above region size");

    a_ucnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= r_usize)
        else $error("user free count above region size");

    a_fill_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kw <= r_kcnt) && (r_uw <= r_ucnt))
        else $error("fill mark above free count");

    a_idle_no_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_left == '0))
        else $error("ready with allocation pages still pending");

endmodule
`default_nettype wire

// ----- test/two_region_page_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
module two_region_page_allocator_unit_tb;
    import trpa_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest legal
    // quiet stretch is the receiver hold-off below plus a few stall streaks.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int unsigned HOLD_CYCLES    = 300;
    // Idle cycles after the last result before a register write or the run's end.
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam logic [63:0] ADDR_MASK      = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAGE_MASK      = (64'd1 << PAGE_SHIFT) - 64'd1;

    // One result as the block should produce it.
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  free_cnt;
        logic              last;
    } grant_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    two_region_page_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Allocator shadow: registers, stacks, free flags and free counts
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  upages_reg;
    logic [KIDX_W-1:0] kernel_stack [KPAGES];
    logic [UIDX_W-1:0] user_stack   [UMAX_PAGES];
    bit                kernel_map   [KPAGES];
    bit                user_map     [UMAX_PAGES];
    int unsigned       kernel_free;
    int unsigned       user_free;

    // Pages handed out and not yet freed by the stimulus, per region.
    int unsigned       held_kernel[$];
    int unsigned       held_user[$];

    grant_t            expected_grants[$];

    int unsigned       err_cnt = 0;
    int unsigned       src_idle_pct = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       hold_req = 0;
    int unsigned       hold_seen = 0;
    int unsigned       hold_left = 0;
    int unsigned       quiet_cycles = 0;

    // Kernel base is rounded up to a page and wraps at 56 bits; the user base
    // follows the kernel pages and is deliberately not wrapped.
    function automatic logic [63:0] region_base(bit kern);
        logic [63:0] kbase;
        kbase = (({8'h00, base_reg} + PAGE_MASK) & ~PAGE_MASK) & ADDR_MASK;
        return kern ? kbase : kbase + (64'(KPAGES) << PAGE_SHIFT);
    endfunction

    function automatic int unsigned user_span();
        return (upages_reg > UMAX_PAGES) ? UMAX_PAGES : int'(upages_reg);
    endfunction

    function automatic logic [ADDR_W-1:0] page_address(bit kern, int unsigned idx);
        return ADDR_W'(region_base(kern) + (64'(idx) << PAGE_SHIFT));
    endfunction

    // Every page of both regions free, index 0 on top of each stack.
    function automatic void rebuild_free_lists();
        int unsigned span;
        span = user_span();
        for (int i = 0; i < KPAGES; i++) begin
            kernel_stack[i] = KIDX_W'(KPAGES - 1 - i);
            kernel_map[i]   = 1'b1;
        end
        for (int i = 0; i < UMAX_PAGES; i++) begin
            user_stack[i] = (i < span) ? UIDX_W'(span - 1 - i) : '0;
            user_map[i]   = (i < span);
        end
        kernel_free = KPAGES;
        user_free   = span;
        held_kernel.delete();
        held_user.delete();
    endfunction

    function automatic void expect_grant(t_status st, logic [ADDR_W-1:0] addr,
                                         int unsigned cnt, bit last);
        grant_t g;
        g.status   = st;
        g.addr     = addr;
        g.free_cnt = CNT_W'(cnt);
        g.last     = last;
        expected_grants.push_back(g);
    endfunction

    // Advance the shadow by one accepted item and queue the results it causes.
    function automatic void predict_item(t_mode mode, bit kern, logic [ADDR_W-1:0] addr,
                                         logic [WANT_W-1:0] want);
        logic [63:0]       rbase;
        logic [63:0]       offs;
        int unsigned       span;
        int unsigned       cnt;
        int unsigned       idx;
        int unsigned       n;
        t_status           st;
        logic [ADDR_W-1:0] granted[$];
        rbase = region_base(kern);
        span  = kern ? KPAGES : user_span();
        cnt   = kern ? kernel_free : user_free;
        case (mode)
            MODE_FREE: begin
                st   = STAT_OK;
                offs = {8'h00, addr} - rbase;
                if ((addr & PAGE_MASK[ADDR_W-1:0]) != '0) begin
                    st = STAT_MISALIGNED;
                end else if ({8'h00, addr} < rbase || (offs >> PAGE_SHIFT) >= span) begin
                    st = STAT_OUT_OF_RGN;
                end else begin
                    idx = int'(offs >> PAGE_SHIFT);
                    if (kern ? kernel_map[idx] : user_map[idx]) begin
                        st = STAT_DOUBLE_FREE;
                    end else if (cnt < span) begin
                        // push the page back on top of its stack
                        if (kern) begin
                            kernel_map[idx]   = 1'b1;
                            kernel_stack[cnt] = KIDX_W'(idx);
                        end else begin
                            user_map[idx]   = 1'b1;
                            user_stack[cnt] = UIDX_W'(idx);
                        end
                        cnt++;
                    end
                end
                expect_grant(st, '0, cnt, 1'b1);
            end
            MODE_ALLOC: begin
                n = (want > MAX_BURST) ? MAX_BURST : int'(want);
                if (n == 0) begin
                    expect_grant(STAT_OK, '0, cnt, 1'b1);
                end else begin
                    // pop until the burst is full or the region runs dry
                    while (granted.size() < n && cnt > 0) begin
                        cnt--;
                        if (kern) begin
                            idx = kernel_stack[cnt];
                            kernel_map[idx] = 1'b0;
                            held_kernel.push_back(idx);
                        end else begin
                            idx = user_stack[cnt];
                            user_map[idx] = 1'b0;
                            held_user.push_back(idx);
                        end
                        granted.push_back(page_address(kern, idx));
                    end
                    if (granted.size() == 0) begin
                        expect_grant(STAT_NONE_AVAIL, '0, cnt, 1'b1);
                    end else begin
                        foreach (granted[k]) begin
                            expect_grant(STAT_OK, granted[k], cnt, k == granted.size() - 1);
                        end
                    end
                end
            end
            default: begin
                // query, and the spare mode that acts as one
                expect_grant(STAT_OK, '0, cnt, 1'b1);
            end
        endcase
        if (kern) begin
            kernel_free = cnt;
        end else begin
            user_free = cnt;
        end
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic report_error(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each output transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        grant_t exp_g;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_grants.size() == 0) begin
                report_error($sformatf("unexpected result tdata=%h tuser=%h tlast=%b",
                                       o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                exp_g = expected_grants.pop_front();
                if (o_m_tuser !== exp_g.status)
                    report_error($sformatf("status got %0d expected %0d",
                                           o_m_tuser, exp_g.status));
                if (o_m_tdata[ADDR_W-1:0] !== exp_g.addr)
                    report_error($sformatf("granted_addr got %h expected %h",
                                           o_m_tdata[ADDR_W-1:0], exp_g.addr));
                if (o_m_tdata[ADDR_W +: CNT_W] !== exp_g.free_cnt)
                    report_error($sformatf("free_pages got %0d expected %0d",
                                           o_m_tdata[ADDR_W +: CNT_W], exp_g.free_cnt));
                if (o_m_tlast !== exp_g.last)
                    report_error($sformatf("last got %b expected %b",
                                           o_m_tlast, exp_g.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing transfers for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item, idling first at the current sender rate, and hold it until
    // the transfer; valid stays high so back-to-back items need no extra step.
    task automatic send_item(t_mode mode, bit kern, logic [ADDR_W-1:0] addr,
                             logic [WANT_W-1:0] want);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({want, addr});
        i_s_tuser  <= {kern, mode};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        predict_item(mode, kern, addr, want);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only on an idle block; every write frees all pages again.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ALLOC_BASE) begin
            base_reg = value;
        end else begin
            upages_reg = value[CNT_W-1:0];
        end
        rebuild_free_lists();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every mode and every free error on the reset configuration.
    task automatic test_basic_ops();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(MODE_QUERY, 1'b1, '0, '0);
        send_item(MODE_SPARE, 1'b0, '1, '1);
        send_item(MODE_ALLOC, 1'b1, '0, 7'd0);
        send_item(MODE_ALLOC, 1'b1, '1, 7'd1);
        // oversized request, clamped to a full burst
        send_item(MODE_ALLOC, 1'b0, '0, 7'd127);
        send_item(MODE_FREE, 1'b1, page_address(1'b1, 0) | 56'h1, 7'd0);
        send_item(MODE_FREE, 1'b1, '1, 7'd0);
        send_item(MODE_FREE, 1'b1, '0, 7'd0);
        send_item(MODE_FREE, 1'b1, page_address(1'b1, KPAGES), 7'd0);
        send_item(MODE_FREE, 1'b1, page_address(1'b1, 5), 7'd0);
        send_item(MODE_FREE, 1'b1, page_address(1'b1, 0), 7'd127);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, 63), 7'd0);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, 63), 7'd0);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, user_span()), 7'd0);
    endtask

    // Register extremes: tiny, empty and oversized user region; kernel base at
    // the top of the address space, both rounded to zero and wrapping.
    task automatic test_register_cases();
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(3));
        send_item(MODE_ALLOC, 1'b0, '0, 7'd5);   // partial grant
        send_item(MODE_ALLOC, 1'b0, '0, 7'd1);   // region empty
        send_item(MODE_FREE, 1'b0, page_address(1'b0, 1), 7'd0);
        send_item(MODE_QUERY, 1'b0, '0, '0);
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(0));
        send_item(MODE_ALLOC, 1'b0, '0, 7'd2);
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(16'hFFFF));
        send_item(MODE_QUERY, 1'b0, '0, '0);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, UMAX_PAGES - 1), 7'd0);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, UMAX_PAGES), 7'd0);
        write_reg(CFG_ALLOC_BASE, '1);
        send_item(MODE_ALLOC, 1'b1, '0, 7'd2);
        send_item(MODE_FREE, 1'b1, '0, 7'd0);
        // 32 kernel pages below the top, the rest wraps to address zero
        write_reg(CFG_ALLOC_BASE, CFG_DATA_W'(56'hFF_FFFF_FFFE_0000));
        send_item(MODE_ALLOC, 1'b1, '0, 7'd64);
        send_item(MODE_FREE, 1'b1, '0, 7'd0);
        send_item(MODE_ALLOC, 1'b0, '0, 7'd1);
        send_item(MODE_FREE, 1'b0, page_address(1'b0, 0), 7'd0);
    endtask

    // Block the output for a long stretch while items keep coming, so the input
    // side backs up, then pause until the block has emptied.
    task automatic test_output_hold_off();
        write_reg(CFG_ALLOC_BASE, BASE_RST);
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(UPAGES_RST));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 10; i++) begin
            send_item(MODE_ALLOC, i[0], rand_addr(), WANT_W'(i % 4 + 1));
        end
        wait_drained();
    endtask

    // Mostly alloc/free traffic on pages that were actually handed out, with
    // double frees, stray addresses and queries mixed in.
    task automatic run_random_phase(int unsigned n_items, int unsigned idle_pct,
                                    int unsigned stall_pct);
        int unsigned       pick;
        int unsigned       span;
        int unsigned       j;
        int unsigned       idx;
        int unsigned       w;
        bit                kern;
        bit                do_alloc;
        logic [ADDR_W-1:0] addr;
        logic [WANT_W-1:0] want;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n_items) begin
            kern     = $urandom_range(1);
            pick     = $urandom_range(99);
            addr     = rand_addr();
            want     = WANT_W'($urandom_range(127));
            span     = kern ? KPAGES : user_span();
            do_alloc = (pick < 40)
                     || (pick < 75 && (kern ? held_kernel.size() : held_user.size()) == 0);
            if (do_alloc) begin
                w    = $urandom_range(99);
                want = (w < 5)  ? WANT_W'(0)
                     : (w < 88) ? WANT_W'($urandom_range(1, 8))
                     : WANT_W'($urandom_range(9, 127));
                send_item(MODE_ALLOC, kern, addr, want);
            end else if (pick < 75) begin
                // give back a page that is currently held
                if (kern) begin
                    j   = $urandom_range(held_kernel.size() - 1);
                    idx = held_kernel[j];
                    held_kernel.delete(j);
                end else begin
                    j   = $urandom_range(held_user.size() - 1);
                    idx = held_user[j];
                    held_user.delete(j);
                end
                send_item(MODE_FREE, kern, page_address(kern, idx), want);
            end else if (pick < 85) begin
                // any page of the region, or the one just past its end
                send_item(MODE_FREE, kern, page_address(kern, $urandom_range(span)), want);
            end else if (pick < 95) begin
                if ($urandom_range(1)) addr[PAGE_SHIFT-1:0] = '0;
                send_item(MODE_FREE, kern, addr, want);
            end else begin
                send_item(t_mode'($urandom_range(2, 3)), kern, addr, want);
            end
        end
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_ALLOC_BASE, BASE_RST);
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(UPAGES_RST));
        run_random_phase(40, 0, 0);
        write_reg(CFG_ALLOC_BASE, CFG_DATA_W'(56'h12_3456_7001));
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(24));
        run_random_phase(40, 79, 0);
        write_reg(CFG_ALLOC_BASE, CFG_DATA_W'(56'hFF_FFFF_FFFC_0001));
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(16'hFFFF));
        run_random_phase(40, 0, 79);
        write_reg(CFG_ALLOC_BASE, '0);
        write_reg(CFG_USER_PAGES, CFG_DATA_W'(8));
        run_random_phase(40, 18, 18);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ALLOC_BASE;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset leaves the block as after a write of the default values
        base_reg   = BASE_RST;
        upages_reg = UPAGES_RST;
        rebuild_free_lists();

        test_basic_ops();
        test_register_cases();
        test_output_hold_off();
        test_random_traffic();

        wait_drained();
        if (expected_grants.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_grants.size()));
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
